/* src/assert_macros.svh */
// Assertion helpers used by the RTL. Each use names its label, clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed on next cycle");

`endif

/* src/ise_pkg.sv */
`default_nettype none

package ise_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflowed;
	} out_item_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} dp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             count_one;
		logic             slot_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* src/ise_datapath.sv */
`default_nettype none

module ise_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ise_pkg::dp_cmd_t  cmd,
	input  ise_pkg::in_item_t src_item,
	input  logic              res_stall,
	output ise_pkg::dp_status_t status,
	output logic              res_valid,
	output ise_pkg::out_item_t res_item
);
	import ise_pkg::*;

	logic signed [31:0] store_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic               overflow_q;
	logic               res_valid_q;
	out_item_t          res_item_q;
	logic [CAPACITY-1:0] gt;
	logic               full;
	logic               do_insert;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign do_insert = cmd.insert && !full;

	// Each occupied entry compares itself against the incoming value. The row is
	// sorted, so the entries that are strictly greater form one run at the top.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (store_q[i] > src_item.value);
		end
	end

	// Greater entries move up one place; the value lands just below the run.
	// Popping moves every entry down one place toward the head.
	always_ff @(posedge clk) begin
		if (do_insert) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					store_q[i] <= store_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || CNT_W'(i) == count_q) begin
					store_q[i] <= src_item.value;
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				store_q[i] <= store_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.insert && full) begin
				overflow_q <= 1'b1;
			end else if (cmd.pop && status.count_one) begin
				overflow_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			res_item_q.sorted_value <= store_q[0];
			res_item_q.last_out     <= status.count_one;
			res_item_q.overflowed   <= overflow_q;
		end
	end

	assign status.count     = count_q;
	assign status.count_one = (count_q == CNT_W'(1));
	assign status.slot_free = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

`default_nettype wire

/* src/ise_ctrl.sv */
`default_nettype none

module ise_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  logic                src_last,
	input  ise_pkg::dp_status_t status,
	output logic                src_stall,
	output ise_pkg::dp_cmd_t    cmd
);
	import ise_pkg::*;

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_DRAIN  = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd.insert = 1'b0;
		cmd.pop    = 1'b0;
		src_stall  = 1'b1;
		state_d    = state_q;
		case (state_q)
			ST_ACCEPT: begin
				src_stall  = 1'b0;
				cmd.insert = src_valid;
				if (src_valid && src_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.pop = status.slot_free;
				if (status.slot_free && status.count_one) begin
					state_d = ST_ACCEPT;
				end
			end
			default: begin
				state_d = ST_ACCEPT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* src/insertion_sort_engine.sv */
// Channel   Direction  Handshake            Payload
// src       input      src_valid/src_stall  in_item_t  {value, last_in}
// res       output     res_valid/res_stall  out_item_t {sorted_value, last_out, overflowed}
//
// An input item is taken every cycle while the engine collects a batch; the
// parallel compare-and-shift over the register row inserts it as it is taken.
// After an item with last_in, the batch drains from the head of the row, one
// result per cycle while res is not stalled, and src_stall stays high.
// A stall on res holds the output register and pauses the drain.
// Reset clears the element count, the overflow flag and the controller; the
// stored values themselves are not reset.
`default_nettype none

`include "assert_macros.svh"

module insertion_sort_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  ise_pkg::in_item_t  src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output ise_pkg::out_item_t res_item
);
	import ise_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	ise_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_last  (src_item.last_in),
		.status    (status),
		.src_stall (src_stall),
		.cmd       (cmd)
	);

	ise_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.src_item  (src_item),
		.res_stall (res_stall),
		.status    (status),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	`ASSERT_SAME(a_count_in_range, clk, arst_n, 1'b1, status.count <= CNT_W'(CAPACITY))
	`ASSERT_SAME(a_pop_not_empty, clk, arst_n, cmd.pop, status.count != '0)
	`ASSERT_SAME(a_insert_pop_excl, clk, arst_n, cmd.insert, !cmd.pop)
	`ASSERT_NEXT(a_last_starts_drain, clk, arst_n, src_valid && !src_stall && src_item.last_in, src_stall)

endmodule

`default_nettype wire

/* sim/insertion_sort_engine_tb.sv */
`timescale 1ns / 1ps

module insertion_sort_engine_tb;
	import ise_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 80;

	// Keeps its own sorted row and produces the batch that a final item releases.
	class sort_tracker;
		logic signed [31:0] row [CAPACITY];
		int fill;
		bit dropped;
		out_item_t sorted_due [$];
		int errors;
		int batches;
		int overflow_batches;
		int checked;

		task report(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		function void note_value(input in_item_t it);
			int pos;
			out_item_t due;
			if (fill < CAPACITY) begin
				pos = fill;
				// Equal values stay behind earlier ones, so only strictly greater entries move.
				while (pos > 0 && $signed(row[pos - 1]) > $signed(it.value)) begin
					row[pos] = row[pos - 1];
					pos--;
				end
				row[pos] = it.value;
				fill++;
			end else begin
				dropped = 1'b1;
			end
			if (it.last_in) begin
				for (int k = 0; k < fill; k++) begin
					due.sorted_value = row[k];
					due.last_out     = (k == fill - 1);
					due.overflowed   = dropped;
					sorted_due.push_back(due);
				end
				batches++;
				if (dropped)
					overflow_batches++;
				fill = 0;
				dropped = 1'b0;
			end
		endfunction

		task check_sorted(input out_item_t got);
			out_item_t want;
			if (sorted_due.size() == 0) begin
				report($sformatf("unexpected result value=%0d last=%b ovf=%b",
					got.sorted_value, got.last_out, got.overflowed));
			end else begin
				want = sorted_due.pop_front();
				checked++;
				if (got.sorted_value !== want.sorted_value)
					report($sformatf("sorted_value %0d, expected %0d",
						got.sorted_value, want.sorted_value));
				if (got.last_out !== want.last_out)
					report($sformatf("last_out %b, expected %b", got.last_out, want.last_out));
				if (got.overflowed !== want.overflowed)
					report($sformatf("overflowed %b, expected %b",
						got.overflowed, want.overflowed));
			end
		endtask

		function int pending();
			return sorted_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	in_item_t src_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_item_t res_item;

	int src_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	sort_tracker tracker = new();

	insertion_sort_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	always #5 clk = ~clk;

	// Output side: either a long hold-off on request or random stalls.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall)
				tracker.note_value(src_item);
			if (res_valid && !res_stall)
				tracker.check_sorted(res_item);
			if ((src_valid && !src_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_item(input logic signed [31:0] v, input logic last);
		in_item_t it;
		it.value = v;
		it.last_in = last;
		if ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			src_item <= {$urandom, 1'($urandom)};
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= it;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_batch(input int len);
		for (int k = 0; k < len; k++)
			send_item(pick_value(), k == len - 1);
	endtask

	// The sender goes idle so that the item just taken is not offered again.
	task automatic drain_all();
		src_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int len;
		int phase_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lone extreme, all the extremes in one batch, then a descending batch
		// with duplicates that fills the store and drops its last two values.
		send_item(32'sh7fff_ffff, 1'b1);
		send_item(32'sh0000_0000, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(32'sd1, 1'b1);
		for (int k = 0; k < CAPACITY + 2; k++)
			send_item((CAPACITY + 1 - k) / 2, k == CAPACITY + 1);
		drain_all();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  stall_pct = 0;  end
				1: begin src_idle_pct = 52; stall_pct = 0;  end
				2: begin src_idle_pct = 0;  stall_pct = 52; end
				default: begin src_idle_pct = 28; stall_pct = 28; end
			endcase
			phase_start = items_sent;
			if (phase == 0) begin
				// Results are held back while the next batch is already offered.
				hold_req = 1'b1;
				send_batch(5);
				send_batch(8);
			end
			while (items_sent - phase_start < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0: len = $urandom_range(CAPACITY - 2, CAPACITY + 4);
					1: len = CAPACITY;
					default: len = $urandom_range(1, 6);
				endcase
				send_batch(len);
				if ($urandom_range(0, 7) == 0)
					drain_all();
			end
			drain_all();
		end

		repeat (CAPACITY + 8) @(posedge clk);
		$display("Sent %0d items in %0d batches (%0d with dropped values); %0d results checked.",
			items_sent, tracker.batches, tracker.overflow_batches, tracker.checked);
		$display("Ran with no idling, sender gaps, output stalls, both, and one long hold-off.");
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
